// ===== src/pidc_pkg.sv =====
// shared types and constants of the clamped pid controller
// no dependencies; used by pidc_div and pid_controller_clamped

package pidc_pkg;

  localparam int unsigned DvdW = 64;
  localparam int unsigned DivW = 33;
  localparam int unsigned CntW = 7;

  // the derivative divide runs over the 46 bits that |de| * clock rate can reach
  localparam logic [CntW-1:0] IterDeriv = 7'd46;

  localparam logic [2:0] RegGainProp  = 3'd0;
  localparam logic [2:0] RegGainInteg = 3'd1;
  localparam logic [2:0] RegGainDeriv = 3'd2;
  localparam logic [2:0] RegIntegLim  = 3'd3;
  localparam logic [2:0] RegDerivLim  = 3'd4;
  localparam logic [2:0] RegOutLim    = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_QEST,
    ST_QMUL,
    ST_QFIX,
    ST_INT_UPD,
    ST_MUL_D,
    ST_DIV_D_GO,
    ST_DIV_D_RUN,
    ST_DER_UPD,
    ST_MP,
    ST_AP,
    ST_MIH,
    ST_AIH,
    ST_MIL,
    ST_AIL,
    ST_MD,
    ST_AD,
    ST_RND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] iters;
  } div_req_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

endpackage

// ===== src/pidc_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on pidc_pkg for widths and the request struct

module pidc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  pidc_pkg::div_req_t                req,
  input  logic [pidc_pkg::DvdW-1:0]         dividend,
  input  logic [pidc_pkg::DivW-2:0]         divisor,
  output logic                              busy,
  output logic [pidc_pkg::DvdW-1:0]         quotient
);

  logic [pidc_pkg::DvdW-1:0] dvd;
  logic [pidc_pkg::DivW-1:0] rem;
  logic [pidc_pkg::DivW-1:0] dsr;
  logic [pidc_pkg::CntW-1:0] cnt;
  logic [pidc_pkg::DivW-1:0] rem_sh;
  logic                      fits;

  assign rem_sh   = {rem[pidc_pkg::DivW-2:0], dvd[pidc_pkg::DvdW-1]};
  assign fits     = rem_sh >= dsr;
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.iters;
      dvd  <= dividend;
      rem  <= '0;
      dsr  <= {1'b0, divisor};
    end else if (busy) begin
      // quotient bits shift in from the bottom as dividend bits leave the top
      rem  <= fits ? rem_sh - dsr : rem_sh;
      dvd  <= {dvd[pidc_pkg::DvdW-2:0], fits};
      cnt  <= cnt - 1'b1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

endmodule

// ===== src/pid_controller_clamped.sv =====
// top level of the clamped pid controller: stream ports, config registers, sequencer
// depends on pidc_pkg and pidc_div

// One word in, one drive word out. A step runs the integral divide by the clock
// rate (four 16-bit quotient digits, each a reciprocal estimate, a back multiply
// and one correction on the shared 33x33 multiplier) and the derivative divide
// by the tick count in the bit-serial divider, around the other multiplies,
// updates and accumulation. A step with zero ticks skips the derivative divide.
// The input is not ready until the drive word is taken.
module pid_controller_clamped #(
  parameter int unsigned CLOCK_HZ = 16000000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // setpoint[15:0], measurement[31:16], elapsed_ticks[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // drive[15:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [46:0] cfg_data
);

  localparam logic [31:0] Hz = 32'(CLOCK_HZ);
  // reciprocal of the clock rate for the digit estimate; the partial
  // remainder and digit stay below Hz * 2^16
  localparam int unsigned HzBits = $clog2(CLOCK_HZ + 1);
  localparam int unsigned QSh    = (HzBits > 16) ? HzBits - 16 : 0;
  localparam int unsigned QPos   = HzBits + 30 - QSh;
  localparam logic [31:0] Recip  = 32'((64'd1 << (HzBits + 30)) / 64'(CLOCK_HZ));

  pidc_pkg::state_t state, state_next;

  logic signed [31:0] gain_prop, gain_integ, gain_deriv;
  logic [46:0]        integral_limit;
  logic [30:0]        derivative_limit;
  logic [14:0]        output_limit;

  logic signed [47:0] integral_sum;
  logic signed [16:0] previous_error;
  logic signed [16:0] err;
  logic [31:0]        ticks;
  logic signed [31:0] deriv;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic [15:0]        drive;

  logic signed [17:0] de;
  logic [16:0]        err_mag;
  logic [17:0]        de_mag;
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod_full;

  pidc_pkg::div_req_t        div_req;
  logic [pidc_pkg::DvdW-1:0] div_dividend;
  logic [31:0]               div_divisor;
  logic                      div_busy;
  logic [pidc_pkg::DvdW-1:0] div_quot;

  // integral divide by the clock rate, 16-bit digits from the top
  logic [47:0] qnum;
  logic [31:0] qrem;
  logic [63:0] qacc;
  logic [15:0] qdig;
  logic [1:0]  qcnt;
  logic [47:0] q_x;
  logic [31:0] q_xhi;
  logic [47:0] q_diff;
  logic        q_fix;
  logic [15:0] q_digit;

  logic signed [63:0] isum;
  logic signed [63:0] ilim;
  logic signed [63:0] acc_rnd;
  logic signed [47:0] drv_full;
  logic signed [47:0] olim;
  logic [45:0]        dmag;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == pidc_pkg::ST_IDLE);
  assign m_tvalid  = (state == pidc_pkg::ST_OUT);
  assign m_tdata   = drive;

  assign de      = 18'(err) - 18'(previous_error);
  assign err_mag = err[16] ? 17'(-err) : 17'(err);
  assign de_mag  = de[17] ? 18'(-de) : 18'(de);

  assign q_x     = {qrem[31:0], qnum[47:32]};
  assign q_xhi   = 32'(q_x >> QSh);
  assign q_diff  = q_x - prod[47:0];
  assign q_fix   = q_diff >= {16'b0, Hz};
  assign q_digit = q_fix ? qdig + 16'd1 : qdig;

  pidc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // operand select for the one shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      pidc_pkg::ST_MUL_I: begin
        op_a = {16'b0, err_mag};
        op_b = {1'b0, ticks};
      end
      pidc_pkg::ST_QEST: begin
        op_a = {1'b0, q_xhi};
        op_b = {1'b0, Recip};
      end
      pidc_pkg::ST_QMUL: begin
        op_a = {17'b0, qdig};
        op_b = {1'b0, Hz};
      end
      pidc_pkg::ST_MUL_D: begin
        op_a = {15'b0, de_mag};
        op_b = {1'b0, Hz};
      end
      pidc_pkg::ST_MP: begin
        op_a = 33'(gain_prop);
        op_b = 33'(err);
      end
      pidc_pkg::ST_MIH: begin
        op_a = 33'(gain_integ);
        op_b = 33'($signed(integral_sum[47:16]));
      end
      pidc_pkg::ST_MIL: begin
        op_a = 33'(gain_integ);
        op_b = {17'b0, integral_sum[15:0]};
      end
      pidc_pkg::ST_MD: begin
        op_a = 33'(gain_deriv);
        op_b = 33'(deriv);
      end
      default: ;
    endcase
  end

  assign prod_full = op_a * op_b;

  always_comb begin
    div_req.start = (state == pidc_pkg::ST_DIV_D_GO);
    div_req.iters = pidc_pkg::IterDeriv;
    div_dividend  = {prod[45:0], 18'b0};
    div_divisor   = ticks;
  end

  // integral update and clamp, derivative clamp, rounding of the sum and output clamp
  assign isum     = err[16] ? 64'(integral_sum) - $signed(qacc)
                            : 64'(integral_sum) + $signed(qacc);
  assign ilim     = {17'b0, integral_limit};
  assign dmag     = (div_quot[45:0] > 46'(derivative_limit)) ? 46'(derivative_limit)
                                                               : div_quot[45:0];
  assign acc_rnd  = pidc_pkg::sat_add(acc, 64'sd32768);
  assign drv_full = acc_rnd[63:16];
  assign olim     = {33'b0, output_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pidc_pkg::ST_IDLE:      if (s_tvalid) state_next = pidc_pkg::ST_MUL_I;
      pidc_pkg::ST_MUL_I:     state_next = pidc_pkg::ST_QEST;
      pidc_pkg::ST_QEST:      state_next = pidc_pkg::ST_QMUL;
      pidc_pkg::ST_QMUL:      state_next = pidc_pkg::ST_QFIX;
      pidc_pkg::ST_QFIX:      state_next = (qcnt == 2'd3) ? pidc_pkg::ST_INT_UPD
                                                          : pidc_pkg::ST_QEST;
      pidc_pkg::ST_INT_UPD:   state_next = pidc_pkg::ST_MUL_D;
      pidc_pkg::ST_MUL_D:     state_next = (ticks == '0) ? pidc_pkg::ST_DER_UPD
                                                         : pidc_pkg::ST_DIV_D_GO;
      pidc_pkg::ST_DIV_D_GO:  state_next = pidc_pkg::ST_DIV_D_RUN;
      pidc_pkg::ST_DIV_D_RUN: if (!div_busy) state_next = pidc_pkg::ST_DER_UPD;
      pidc_pkg::ST_DER_UPD:   state_next = pidc_pkg::ST_MP;
      pidc_pkg::ST_MP:        state_next = pidc_pkg::ST_AP;
      pidc_pkg::ST_AP:        state_next = pidc_pkg::ST_MIH;
      pidc_pkg::ST_MIH:       state_next = pidc_pkg::ST_AIH;
      pidc_pkg::ST_AIH:       state_next = pidc_pkg::ST_MIL;
      pidc_pkg::ST_MIL:       state_next = pidc_pkg::ST_AIL;
      pidc_pkg::ST_AIL:       state_next = pidc_pkg::ST_MD;
      pidc_pkg::ST_MD:        state_next = pidc_pkg::ST_AD;
      pidc_pkg::ST_AD:        state_next = pidc_pkg::ST_RND;
      pidc_pkg::ST_RND:       state_next = pidc_pkg::ST_OUT;
      pidc_pkg::ST_OUT:       if (m_tready) state_next = pidc_pkg::ST_IDLE;
      default:                state_next = pidc_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      case (state)
        pidc_pkg::ST_IDLE: if (s_tvalid) begin
          err   <= 17'($signed(s_tdata[15:0])) - 17'($signed(s_tdata[31:16]));
          ticks <= s_tdata[63:32];
        end
        pidc_pkg::ST_MUL_I: begin
          // |e| * ticks, divided below as (that << 16) / clock rate
          qnum <= prod_full[47:0];
          qrem <= '0;
          qacc <= '0;
          qcnt <= '0;
        end
        pidc_pkg::ST_QEST: qdig <= prod_full[QPos +: 16];
        pidc_pkg::ST_QFIX: begin
          // the estimate is low by at most one
          qrem <= q_fix ? 32'(q_diff - {16'b0, Hz}) : q_diff[31:0];
          qacc <= {qacc[47:0], q_digit};
          qnum <= {qnum[31:0], 16'b0};
          qcnt <= qcnt + 2'd1;
        end
        pidc_pkg::ST_QMUL, pidc_pkg::ST_MUL_D, pidc_pkg::ST_MP, pidc_pkg::ST_MIH,
        pidc_pkg::ST_MIL, pidc_pkg::ST_MD: prod <= prod_full[63:0];
        pidc_pkg::ST_INT_UPD: begin
          if (isum > ilim)       integral_sum <= ilim[47:0];
          else if (isum < -ilim) integral_sum <= 48'(-ilim);
          else                   integral_sum <= isum[47:0];
        end
        pidc_pkg::ST_DER_UPD: begin
          if (ticks == '0) begin
            if (de == '0)   deriv <= '0;
            else if (de[17]) deriv <= -32'(derivative_limit);
            else            deriv <= 32'(derivative_limit);
          end else begin
            deriv <= de[17] ? -32'(dmag) : 32'(dmag);
          end
          previous_error <= err;
        end
        pidc_pkg::ST_AP:  acc <= prod;
        pidc_pkg::ST_AIH: acc <= pidc_pkg::sat_add(acc, prod);
        pidc_pkg::ST_AIL: acc <= pidc_pkg::sat_add(acc, prod >>> 16);
        pidc_pkg::ST_AD:  acc <= pidc_pkg::sat_add(acc, prod);
        pidc_pkg::ST_RND: begin
          if (drv_full > olim)       drive <= olim[15:0];
          else if (drv_full < -olim) drive <= 16'(-olim);
          else                       drive <= drv_full[15:0];
        end
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop        <= '0;
      gain_integ       <= '0;
      gain_deriv       <= '0;
      integral_limit   <= '1;
      derivative_limit <= '1;
      output_limit     <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        pidc_pkg::RegGainProp:  gain_prop        <= cfg_data[31:0];
        pidc_pkg::RegGainInteg: gain_integ       <= cfg_data[31:0];
        pidc_pkg::RegGainDeriv: gain_deriv       <= cfg_data[31:0];
        pidc_pkg::RegIntegLim:  integral_limit   <= cfg_data;
        pidc_pkg::RegDerivLim:  derivative_limit <= cfg_data[30:0];
        pidc_pkg::RegOutLim:    output_limit     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/pidc_checker.sv =====
// port-level checks of the clamped pid controller, bound to the top level
// no package dependencies

module pidc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // one word in flight: no input taken while a drive word waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input ready while output pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("ready right after accept");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid) else $error("result without computation");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled drive word changed");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
